// ----- design/mob_pkg.sv -----
package mob_pkg;

   localparam int SAMPLE_COUNT = 16;
   localparam int SAMPLE_WIDTH = 16;

   localparam int MEDIAN_WIDTH = SAMPLE_WIDTH + 1;
   localparam int COUNT_WIDTH  = $clog2(SAMPLE_COUNT);

   // lower and upper middle of the sorted block; equal for an odd count
   localparam int MID_LO = (SAMPLE_COUNT - 1) / 2;
   localparam int MID_HI = SAMPLE_COUNT / 2;

   typedef struct packed {
      logic insert;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic last;
   } status_type;

endpackage

// ----- design/mob_channels.sv -----
interface mob_sample_if;
   logic                                      valid;
   logic                                      ready;
   logic signed [mob_pkg::SAMPLE_WIDTH-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

interface mob_median_if;
   logic                                      valid;
   logic                                      ready;
   logic signed [mob_pkg::MEDIAN_WIDTH-1:0] median_value;

   modport source (output valid, output median_value, input ready);
   modport sink   (input valid, input median_value, output ready);
endinterface

// ----- design/mob_datapath.sv -----
module mob_datapath (
   input  logic                                      clock,
   input  logic                                      reset,
   input  mob_pkg::cmd_type                          cmd,
   input  logic signed [mob_pkg::SAMPLE_WIDTH-1:0]   sample,
   output logic signed [mob_pkg::MEDIAN_WIDTH-1:0]   median_value,
   output mob_pkg::status_type                       status
);

   logic signed [mob_pkg::SAMPLE_WIDTH-1:0] store_ff [mob_pkg::SAMPLE_COUNT];
   logic signed [mob_pkg::SAMPLE_WIDTH-1:0] store_in [mob_pkg::SAMPLE_COUNT];
   logic [mob_pkg::SAMPLE_COUNT-1:0]         gt;
   logic [mob_pkg::COUNT_WIDTH-1:0]          count_ff;
   logic [mob_pkg::COUNT_WIDTH-1:0]          count_in;
   logic signed [mob_pkg::MEDIAN_WIDTH-1:0]  median_ff;
   logic signed [mob_pkg::MEDIAN_WIDTH-1:0]  median_in;
   logic signed [mob_pkg::MEDIAN_WIDTH-1:0]  mid_lo;
   logic signed [mob_pkg::MEDIAN_WIDTH-1:0]  mid_hi;

   assign status.last = (count_ff == mob_pkg::COUNT_WIDTH'(mob_pkg::SAMPLE_COUNT - 1));

   // each cell: take the left neighbor if it moves right, else take the new word
   // where it lands, else hold
   always_comb begin
      for (int i = 0; i < mob_pkg::SAMPLE_COUNT; i++) begin
         gt[i] = (mob_pkg::COUNT_WIDTH'(i) < count_ff) && (store_ff[i] > sample);
      end
      store_in[0] = (gt[0] || (count_ff == '0)) ? sample : store_ff[0];
      for (int i = 1; i < mob_pkg::SAMPLE_COUNT; i++) begin
         if (gt[i-1]) begin
            store_in[i] = store_ff[i-1];
         end else if (gt[i] || (mob_pkg::COUNT_WIDTH'(i) == count_ff)) begin
            store_in[i] = sample;
         end else begin
            store_in[i] = store_ff[i];
         end
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.insert) begin
         count_in = status.last ? '0 : count_ff + 1'b1;
      end
   end

   assign mid_lo = {store_ff[mob_pkg::MID_LO][mob_pkg::SAMPLE_WIDTH-1],
                    store_ff[mob_pkg::MID_LO]};
   assign mid_hi = {store_ff[mob_pkg::MID_HI][mob_pkg::SAMPLE_WIDTH-1],
                    store_ff[mob_pkg::MID_HI]};
   assign median_in = mid_lo + mid_hi;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.insert) begin
         store_ff <= store_in;
      end
      if (cmd.load_out) begin
         median_ff <= median_in;
      end
   end

   assign median_value = median_ff;

endmodule

// ----- design/mob_ctrl.sv -----
module mob_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  mob_pkg::status_type status,
   output mob_pkg::cmd_type    cmd
);

   typedef enum logic [1:0] {
      ST_COLLECT = 2'b01,
      ST_MEDIAN  = 2'b10
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      out_valid_ff;
   logic      out_valid_in;

   assign req_ready    = (state_ff == ST_COLLECT);
   assign cmd.insert   = req_valid && req_ready;
   // load the result once the output register is free or being drained
   assign cmd.load_out = (state_ff == ST_MEDIAN) && (!out_valid_ff || rsp_ready);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_COLLECT: begin
            if (cmd.insert && status.last) begin
               state_in = ST_MEDIAN;
            end
         end
         ST_MEDIAN: begin
            if (cmd.load_out) begin
               state_in = ST_COLLECT;
            end
         end
         default: begin
            state_in = ST_COLLECT;
         end
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff && !rsp_ready;
      if (cmd.load_out) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_COLLECT;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_valid = out_valid_ff;

endmodule

// ----- design/median_of_block_core.sv -----
// Channel  Dir  Payload                   Meaning
// req      in   sample [15:0] signed      one sample of the current block
// rsp      out  median_value [16:0] signed twice the block median
//
// A sample is taken every cycle while req_ready is high; the insertion row of cells
// sorts it on arrival. After the last sample of a block, the median state computes the
// median into the output register; it waits there only while rsp stalls with an
// earlier result still held.
// Synchronous reset empties the block and drops any pending result.
// req_ready is low only while a full block waits to load its median.
module median_of_block_core (
   input logic         clock,
   input logic         reset,
   mob_sample_if.sink  req,
   mob_median_if.source rsp
);

   mob_pkg::cmd_type    cmd;
   mob_pkg::status_type status;

   mob_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .status    (status),
      .cmd       (cmd)
   );

   mob_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .sample       (req.sample),
      .median_value (rsp.median_value),
      .status       (status)
   );

   a_last_word_stalls: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready && status.last) |=> !req.ready)
      else $error("input not held off after last word of block");

   a_load_only_when_held: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!req.ready && !cmd.insert))
      else $error("result loaded while input open");

   a_result_after_median: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp.valid) |-> $past(!req.ready))
      else $error("result word without a median cycle");

endmodule

// ----- tb/sv/median_tb_pkg.sv -----
package median_tb_pkg;
   import mob_pkg::*;

   class median_scoreboard;
      logic signed [SAMPLE_WIDTH-1:0] sorted_block[SAMPLE_COUNT];
      int                             fill;
      logic signed [MEDIAN_WIDTH-1:0] medians_due[$];
      int                             failures;

      function new();
         fill     = 0;
         failures = 0;
      endfunction

      // insert one accepted sample; a full block yields one expected median
      function void note_sample(logic signed [SAMPLE_WIDTH-1:0] s);
         int                             pos;
         logic signed [MEDIAN_WIDTH-1:0] lo;
         logic signed [MEDIAN_WIDTH-1:0] hi;
         pos = fill;
         // equal samples stay ahead of the new one
         while (pos > 0 && sorted_block[pos-1] > s) begin
            sorted_block[pos] = sorted_block[pos-1];
            pos--;
         end
         sorted_block[pos] = s;
         fill++;
         if (fill == SAMPLE_COUNT) begin
            lo = MEDIAN_WIDTH'(sorted_block[MID_LO]);
            hi = MEDIAN_WIDTH'(sorted_block[MID_HI]);
            medians_due.push_back(lo + hi);
            fill = 0;
         end
      endfunction

      function void flag(string msg);
         if (failures < 10) $display("MISMATCH: %s", msg);
         failures++;
      endfunction

      function void check_median(logic signed [MEDIAN_WIDTH-1:0] got);
         logic signed [MEDIAN_WIDTH-1:0] want;
         if (medians_due.size() == 0) begin
            flag($sformatf("median %0d with none expected", got));
         end else begin
            want = medians_due.pop_front();
            if (got !== want)
               flag($sformatf("median_value expected %0d actual %0d", want, got));
         end
      endfunction
   endclass

endpackage

// ----- tb/sv/tb_top.sv -----
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import mob_pkg::*;
   import median_tb_pkg::*;

   localparam int HOLD_CYCLES  = 300;
   localparam int STALL_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 2 * SAMPLE_COUNT + 4;
   localparam int PHASES       = 4;
   localparam int BLOCKS_PER_PHASE = 7;

   logic clock;
   logic reset;

   mob_sample_if req_if();
   mob_median_if rsp_if();

   median_of_block_core dut (
      .clock (clock),
      .reset (reset),
      .req   (req_if),
      .rsp   (rsp_if)
   );

   median_scoreboard sb = new();

   int send_idle_pct;
   int recv_stall_pct;
   int hold_asks;
   int idle_count = 0;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // receiver: check each accepted word, then pick the next ready
   initial begin
      int hold_left;
      int holds_served;
      hold_left    = 0;
      holds_served = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_if.valid && rsp_if.ready) sb.check_median(rsp_if.median_value);
         if (hold_asks != holds_served) begin
            holds_served = hold_asks;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // watchdog: end the run if nothing moves for too long
   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         idle_count <= 0;
      else if (idle_count >= STALL_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else
         idle_count <= idle_count + 1;
   end

   task automatic send_sample(input logic signed [SAMPLE_WIDTH-1:0] s);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid  <= 1'b1;
      req_if.sample <= s;
      do @(posedge clock); while (!req_if.ready);
      sb.note_sample(s);
   endtask

   task automatic send_block();
      int                             shape;
      int                             base;
      logic signed [SAMPLE_WIDTH-1:0] s;
      shape = $urandom_range(5);
      base  = $urandom_range(65535);
      for (int i = 0; i < SAMPLE_COUNT; i++) begin
         case (shape)
            0, 1: s = SAMPLE_WIDTH'($urandom_range(65535));
            // extremes only
            2: s = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
            // few distinct values, many ties
            3: s = SAMPLE_WIDTH'(base + $urandom_range(2));
            // base plus the index times a fresh random step of up to 64
            4: s = SAMPLE_WIDTH'(base + i * $urandom_range(64));
            // base minus the index times a fresh random step of up to 64
            default: s = SAMPLE_WIDTH'(base - i * $urandom_range(64));
         endcase
         send_sample(s);
      end
   endtask

   // drop valid, then wait out every result still due
   task automatic close_phase();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (sb.medians_due.size() > 0);
   endtask

   initial begin
      logic signed [SAMPLE_WIDTH-1:0] directed[SAMPLE_COUNT];
      int idle_set[PHASES];
      int stall_set[PHASES];

      directed = '{
         16'sh8000, 16'sh7fff, 16'sh0000, -16'sd1,   16'sd1,    16'sh7fff,
         16'sh8000, 16'sh5555, 16'shaaaa, 16'sd100,  16'sd100,  16'sd100,
         -16'sd100, 16'sh7ffe, 16'sh8001, 16'sh0000
      };
      idle_set  = '{0, 70, 0, 28};
      stall_set = '{0, 0, 70, 28};

      reset          <= 1'b1;
      req_if.valid   <= 1'b0;
      req_if.sample  <= '0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_asks      = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) send_sample(directed[i]);
      // wait for the median of the directed block
      close_phase();

      for (int p = 0; p < PHASES; p++) begin
         send_idle_pct  = idle_set[p];
         recv_stall_pct = stall_set[p];
         // first phase: hold rsp off long enough to back up req
         if (p == 0) hold_asks++;
         for (int b = 0; b < BLOCKS_PER_PHASE; b++) send_block();
         close_phase();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.failures == 0 && sb.medians_due.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
